// File: rtl/lnsw_pkg.sv
`timescale 1ns / 1ps

package lnsw_pkg;

	// Input kind codes.
	localparam logic [1:0] KIND_CMD    = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_NIBBLE = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Positions of register select and enable in the shift register image.
	localparam int unsigned RS_BIT_POS = 0;
	localparam int unsigned EN_BIT_POS = 1;

	// Field widths.
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned VALUE_W = 8;
	localparam int unsigned HOLD_W  = 10;
	localparam int unsigned IMAGE_W = 8;

	// Reset value of the hold time register.
	localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd100;

	// Event sequencer limits: eight shift events, then the latch event.
	localparam logic [3:0] LATCH_IDX = 4'd8;
	// Three images per nibble: enable low, high, low.
	localparam logic [1:0] IMG_EN_HIGH = 2'd1;
	localparam logic [1:0] IMG_LAST    = 2'd2;

	// Strobe codes.
	localparam logic STROBE_SHIFT = 1'b0;
	localparam logic STROBE_LATCH = 1'b1;

	// One classified job between the front and back end.
	typedef struct packed {
		logic               two_nib;
		logic               rs;
		logic [VALUE_W-1:0] data;
	} job_t;

endpackage

// File: rtl/lnsw_if.sv
`timescale 1ns / 1ps

// Input word channel.
interface lnsw_item_if;
	import lnsw_pkg::*;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [VALUE_W-1:0] value;
	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

// Pin event channel.
interface lnsw_result_if;
	import lnsw_pkg::*;
	logic              valid;
	logic              ready;
	logic              serial_bit;
	logic              strobe_res;
	logic [HOLD_W-1:0] hold_us;
	logic              last;
	modport source (output valid, output serial_bit, output strobe_res, output hold_us,
		output last, input ready);
	modport sink (input valid, input serial_bit, input strobe_res, input hold_us,
		input last, output ready);
endinterface

// Configuration write channel for the hold time register.
interface lnsw_cfg_if;
	import lnsw_pkg::*;
	logic              valid;
	logic              ready;
	logic [HOLD_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lnsw_front.sv
`timescale 1ns / 1ps

module lnsw_front (
	input  logic          clk,
	input  logic          arst_n,
	lnsw_item_if.sink     item,
	output logic          push_valid,
	input  logic          push_ready,
	output lnsw_pkg::job_t push_job
);
	import lnsw_pkg::*;

	logic valid_s1;
	job_t job_s1;
	job_t job_d;
	logic keep_d;

	// Classify the incoming word into a job; the unused kind is dropped.
	always_comb begin
		job_d  = '0;
		keep_d = 1'b1;
		unique case (item.kind)
			KIND_CMD: begin
				job_d.two_nib = 1'b1;
				job_d.rs      = 1'b0;
				job_d.data    = item.value;
			end
			KIND_DATA: begin
				job_d.two_nib = 1'b1;
				job_d.rs      = 1'b1;
				job_d.data    = item.value;
			end
			KIND_NIBBLE: begin
				// The single nibble goes to the high half, which is sent first.
				job_d.two_nib = 1'b0;
				job_d.rs      = 1'b0;
				job_d.data    = {item.value[3:0], 4'b0000};
			end
			KIND_UNUSED: begin
				keep_d = 1'b0;
			end
			default: begin
				keep_d = 1'b0;
			end
		endcase
	end

	assign item.ready = !valid_s1 || push_ready;

	// Stage register in front of the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid && keep_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready) begin
			job_s1 <= job_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_job   = job_s1;

endmodule

// File: rtl/lnsw_fifo.sv
`timescale 1ns / 1ps

module lnsw_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  lnsw_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output lnsw_pkg::job_t pop_job
);
	import lnsw_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: rtl/lnsw_back.sv
`timescale 1ns / 1ps

module lnsw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  lnsw_pkg::job_t pop_job,
	lnsw_cfg_if.sink       cfg,
	lnsw_result_if.source  result
);
	import lnsw_pkg::*;

	logic              busy_q;
	job_t              job_q;
	logic              nib_q;
	logic [1:0]        img_q;
	logic [3:0]        bit_q;
	logic [HOLD_W-1:0] hold_q;
	logic              out_valid_q;
	logic              serial_q;
	logic              strobe_q;
	logic [HOLD_W-1:0] hold_out_q;
	logic              last_q;

	logic               advance;
	logic               emit;
	logic               is_latch;
	logic               is_last_img;
	logic               final_nib;
	logic               done_ev;
	logic [3:0]         nibble;
	logic [IMAGE_W-1:0] image;

	// Hold time register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg.valid) begin
			hold_q <= cfg.data;
		end
	end

	// Build the register image of the current nibble and enable phase.
	always_comb begin
		nibble = nib_q ? job_q.data[3:0] : job_q.data[7:4];
		image  = {nibble, 4'b0000} | (IMAGE_W'(job_q.rs) << RS_BIT_POS);
		if (img_q == IMG_EN_HIGH) begin
			image = image | (IMAGE_W'(1) << EN_BIT_POS);
		end
	end

	assign advance     = !out_valid_q || result.ready;
	assign emit        = busy_q && advance;
	assign is_latch    = (bit_q == LATCH_IDX);
	assign is_last_img = (img_q == IMG_LAST);
	assign final_nib   = nib_q || !job_q.two_nib;
	assign done_ev     = emit && is_latch && is_last_img && final_nib;

	// The next job is taken on the final event of the current one, so events run on.
	assign pop_ready = !busy_q || done_ev;

	// Event sequencer: nibble, image and bit counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			nib_q  <= 1'b0;
			img_q  <= '0;
			bit_q  <= '0;
		end else if (pop_valid && pop_ready) begin
			busy_q <= 1'b1;
			nib_q  <= 1'b0;
			img_q  <= '0;
			bit_q  <= '0;
		end else begin
			if (done_ev) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				if (is_latch) begin
					bit_q <= '0;
					if (is_last_img) begin
						img_q <= '0;
						nib_q <= 1'b1;
					end else begin
						img_q <= img_q + 1'b1;
					end
				end else begin
					bit_q <= bit_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			job_q <= pop_job;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (is_latch) begin
				serial_q   <= image[0];
				strobe_q   <= STROBE_LATCH;
				hold_out_q <= is_last_img ? hold_q : '0;
				last_q     <= is_last_img && final_nib;
			end else begin
				// Most significant bit first: bit index b sends image bit 7 - b.
				serial_q   <= image[~bit_q[2:0]];
				strobe_q   <= STROBE_SHIFT;
				hold_out_q <= '0;
				last_q     <= 1'b0;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.serial_bit = serial_q;
	assign result.strobe_res = strobe_q;
	assign result.hold_us    = hold_out_q;
	assign result.last       = last_q;

endmodule

// File: rtl/lcd_nibble_shift_writer_unit.sv
`timescale 1ns / 1ps
// Path: a word passes the front-end stage register, the job queue, the back-end event sequencer
// and the output register. Throughput: one pin event per cycle while the result channel is ready,
// so a byte gives 54 pin events, a single nibble 27, and an unused kind is dropped at the front end.
// The job queue lets the front end take new words while the sequencer is busy.
// Reset: arst_n clears all control state asynchronously and sets the hold time to 100 us.
module lcd_nibble_shift_writer_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	lnsw_item_if.sink     item,
	lnsw_cfg_if.sink      cfg,
	lnsw_result_if.source result
);
	import lnsw_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	lnsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	lnsw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	lnsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.cfg       (cfg),
		.result    (result)
	);

endmodule

// File: rtl/lnsw_checker.sv
`timescale 1ns / 1ps

module lnsw_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic                      res_serial_bit,
	input logic                      res_strobe_res,
	input logic [lnsw_pkg::HOLD_W-1:0] res_hold_us,
	input logic                      res_last
);
	import lnsw_pkg::*;

	// A stalled word holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_serial_bit)
			&& $stable(res_strobe_res) && $stable(res_hold_us) && $stable(res_last))
		else $error("result word changed while stalled");

	// Shift events carry no hold time and never end an item.
	a_shift_plain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_strobe_res == STROBE_SHIFT) |-> (res_hold_us == '0) && !res_last)
		else $error("shift event with hold time or last flag");

	// The final event of an item is always a latch event.
	a_last_latch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_last |-> (res_strobe_res == STROBE_LATCH))
		else $error("last flag on a non-latch event");

	// No result is offered while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind lcd_nibble_shift_writer_unit lnsw_checker u_lnsw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_serial_bit (result.serial_bit),
	.res_strobe_res (result.strobe_res),
	.res_hold_us    (result.hold_us),
	.res_last       (result.last)
);
